>>> design/printf_integer_char_formatter_defines.svh
// Assertion macros for the printf integer/char formatter.
// Included by files that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef PRINTF_INTEGER_CHAR_FORMATTER_DEFINES_SVH
`define PRINTF_INTEGER_CHAR_FORMATTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define PIC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PIC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PIC_ASSERT(name, prop, msg)
`define PIC_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

>>> design/pic_pkg.sv
// Shared types, codes and constants for the printf integer/char formatter.
// No dependencies; the front end, queue, back end and top level refer to it by scoped names.
package pic_pkg;

	localparam int VALUE_W        = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGIT_DEPTH    = 11;
	localparam int CNT_W          = 4;
	localparam int DIGIT_IDX_W    = $clog2(DIGIT_DEPTH);
	localparam int QUEUE_DEPTH    = 2;

	// Operation codes
	localparam logic [2:0] OP_CHAR      = 3'd0;
	localparam logic [2:0] OP_CHAR_ROT  = 3'd1;
	localparam logic [2:0] OP_PERCENT   = 3'd2;
	localparam logic [2:0] OP_DEC       = 3'd3;
	localparam logic [2:0] OP_HEX_LOWER = 3'd4;
	localparam logic [2:0] OP_HEX_UPPER = 3'd5;

	// ASCII constants
	localparam logic [7:0] CH_ZERO          = 8'h30;
	localparam logic [7:0] CH_MINUS         = 8'h2D;
	localparam logic [7:0] CH_PERCENT       = 8'h25;
	localparam logic [7:0] LOWER_HEX_OFFSET = 8'h57;
	localparam logic [7:0] UPPER_HEX_OFFSET = 8'h37;
	localparam logic [7:0] ROT_SHIFT        = 8'd13;

	// Reciprocal of ten: floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x
	localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int          RECIP10_SHIFT = 35;

	typedef struct packed {
		logic [2:0]         operation;
		logic [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       char_out;
		logic             last;
		logic [CNT_W-1:0] total_chars;
	} out_item_t;

	// Classified conversion passed from front to back
	typedef struct packed {
		logic               has_prefix;
		logic [7:0]         prefix;
		logic               numeric;
		logic               hex;
		logic               upper;
		logic [VALUE_W-1:0] mag;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> design/pic_front.sv
// Front end: accepts requests, classifies the operation and forms the magnitude.
// Depends on pic_pkg; feeds pic_queue.
module pic_front #(
	parameter int VALUE_BITS = pic_pkg::VALUE_BITS_DEF
) (
	input  pic_pkg::in_item_t request,
	input  logic              request_valid,
	output logic              request_stall,
	input  pic_pkg::q_status_t qstat,
	output logic              push,
	output pic_pkg::cmd_t     cmd
);

	localparam int MAG_BITS = (VALUE_BITS < pic_pkg::VALUE_W) ? VALUE_BITS : pic_pkg::VALUE_W;
	localparam bit SIGNED_DEC = (VALUE_BITS <= pic_pkg::VALUE_W);
	localparam logic [pic_pkg::VALUE_W-1:0] VMASK =
		{pic_pkg::VALUE_W{1'b1}} >> (pic_pkg::VALUE_W - MAG_BITS);

	logic [pic_pkg::VALUE_W-1:0] v;
	logic [pic_pkg::VALUE_W-1:0] neg_v;
	logic                        is_neg;
	logic [7:0]                  byte_in;
	logic [7:0]                  rot_byte;
	logic                        known_op;

	// Mask the value and form the two's complement magnitude
	assign v       = request.value & VMASK;
	assign neg_v   = ({pic_pkg::VALUE_W{1'b0}} - v) & VMASK;
	assign is_neg  = SIGNED_DEC && v[MAG_BITS-1];
	assign byte_in = request.value[7:0];

	// Rotate letters by thirteen places
	always_comb begin
		if ((byte_in >= 8'h41 && byte_in <= 8'h4D) || (byte_in >= 8'h61 && byte_in <= 8'h6D)) begin
			rot_byte = byte_in + pic_pkg::ROT_SHIFT;
		end else if ((byte_in >= 8'h4E && byte_in <= 8'h5A) ||
			(byte_in >= 8'h6E && byte_in <= 8'h7A)) begin
			rot_byte = byte_in - pic_pkg::ROT_SHIFT;
		end else begin
			rot_byte = byte_in;
		end
	end

	// Classify the operation
	always_comb begin
		cmd      = '0;
		known_op = 1'b1;
		unique case (request.operation)
			pic_pkg::OP_CHAR: begin
				cmd.has_prefix = 1'b1;
				cmd.prefix     = byte_in;
			end
			pic_pkg::OP_CHAR_ROT: begin
				cmd.has_prefix = 1'b1;
				cmd.prefix     = rot_byte;
			end
			pic_pkg::OP_PERCENT: begin
				cmd.has_prefix = 1'b1;
				cmd.prefix     = pic_pkg::CH_PERCENT;
			end
			pic_pkg::OP_DEC: begin
				cmd.has_prefix = is_neg;
				cmd.prefix     = pic_pkg::CH_MINUS;
				cmd.numeric    = 1'b1;
				cmd.mag        = is_neg ? neg_v : v;
			end
			pic_pkg::OP_HEX_LOWER: begin
				cmd.numeric = 1'b1;
				cmd.hex     = 1'b1;
				cmd.mag     = v;
			end
			pic_pkg::OP_HEX_UPPER: begin
				cmd.numeric = 1'b1;
				cmd.hex     = 1'b1;
				cmd.upper   = 1'b1;
				cmd.mag     = v;
			end
			default: begin
				known_op = 1'b0;
			end
		endcase
	end

	// Accept while the queue has room; drop unknown operations
	assign request_stall = qstat.full;
	assign push          = request_valid && !qstat.full && known_op;

endmodule

>>> design/pic_queue.sv
// Short command queue between front and back end.
// Depends on pic_pkg for the command and status types.
module pic_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pic_pkg::cmd_t      wr_cmd,
	input  logic               pop,
	output pic_pkg::cmd_t      rd_cmd,
	output pic_pkg::q_status_t qstat
);

	localparam int PTR_W = (pic_pkg::QUEUE_DEPTH > 1) ? $clog2(pic_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(pic_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pic_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(pic_pkg::QUEUE_DEPTH);

	pic_pkg::cmd_t    entry_q [pic_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_cmd      = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/pic_back.sv
// Back end: generates digits into a small buffer, then emits characters most significant first.
// Depends on pic_pkg; reads commands from pic_queue.
module pic_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pic_pkg::cmd_t      cmd,
	input  pic_pkg::q_status_t qstat,
	output logic               pop,
	output pic_pkg::out_item_t result,
	output logic               result_valid,
	input  logic               result_stall
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GEN  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam int VW  = pic_pkg::VALUE_W;
	localparam int CW  = pic_pkg::CNT_W;
	localparam int IW  = pic_pkg::DIGIT_IDX_W;
	localparam logic [CW-1:0] DEPTH_CNT = CW'(pic_pkg::DIGIT_DEPTH);

	logic [1:0]        state_q;
	logic              pre_q;
	logic [7:0]        prefix_q;
	logic [VW-1:0]     mag_q;
	logic              hex_q;
	logic              upper_q;
	logic [CW-1:0]     nd_q;
	logic [CW-1:0]     total_q;
	logic [7:0]        digit_q [pic_pkg::DIGIT_DEPTH];
	pic_pkg::out_item_t out_q;
	logic              out_valid_q;

	logic [2*VW-1:0]   prod;
	logic [VW-1:0]     quot;
	logic [VW-1:0]     rem_full;
	logic [3:0]        dig;
	logic [VW-1:0]     next_mag;
	logic [7:0]        dig_char;
	logic [CW-1:0]     nd_next;
	logic              gen_done;
	logic              out_free;
	logic              last_now;
	logic [7:0]        emit_char;
	logic [CW-1:0]     rd_idx;

	// Divide by ten through the reciprocal; hex takes the low nibble
	assign prod     = {{VW{1'b0}}, mag_q} * {{VW{1'b0}}, pic_pkg::RECIP10};
	assign quot     = VW'(prod >> pic_pkg::RECIP10_SHIFT);
	assign rem_full = mag_q - ((quot << 3) + (quot << 1));
	assign dig      = hex_q ? mag_q[3:0] : rem_full[3:0];
	assign next_mag = hex_q ? (mag_q >> 4) : quot;
	assign dig_char = (dig < 4'd10) ? (pic_pkg::CH_ZERO + {4'b0, dig}) :
		({4'b0, dig} + (upper_q ? pic_pkg::UPPER_HEX_OFFSET : pic_pkg::LOWER_HEX_OFFSET));
	assign nd_next  = nd_q + 1'b1;
	assign gen_done = (next_mag == '0) || (nd_next == DEPTH_CNT);

	// Pick the next character to emit
	assign out_free  = !out_valid_q || !result_stall;
	assign rd_idx    = nd_q - 1'b1;
	assign last_now  = pre_q ? (nd_q == '0) : (nd_q == CW'(1));
	assign emit_char = pre_q ? prefix_q : digit_q[rd_idx[IW-1:0]];

	assign pop          = (state_q == ST_IDLE) && !qstat.empty;
	assign result       = out_q;
	assign result_valid = out_valid_q;

	// Write digits least significant first
	always_ff @(posedge clk) begin
		if (state_q == ST_GEN) begin
			digit_q[nd_q[IW-1:0]] <= dig_char;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				prefix_q <= cmd.prefix;
				mag_q    <= cmd.mag;
				hex_q    <= cmd.hex;
				upper_q  <= cmd.upper;
				total_q  <= CW'(1);
			end
			ST_GEN: begin
				mag_q <= next_mag;
				if (gen_done) begin
					total_q <= CW'(pre_q) + nd_next;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q.char_out    <= emit_char;
					out_q.last        <= last_now;
					out_q.total_chars <= last_now ? total_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequence: pop, generate digits for numeric conversions, emit characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pre_q       <= 1'b0;
			nd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= (state_q == ST_EMIT);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						pre_q   <= cmd.has_prefix;
						nd_q    <= '0;
						state_q <= cmd.numeric ? ST_GEN : ST_EMIT;
					end
				end
				ST_GEN: begin
					nd_q <= nd_next;
					if (gen_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (pre_q) begin
							pre_q <= 1'b0;
						end else begin
							nd_q <= rd_idx;
						end
						if (last_now) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/printf_integer_char_formatter.sv
// Top level of the printf integer/char formatter: front end, command queue, back end.
// Depends on pic_pkg, pic_front, pic_queue, pic_back and the assertion macro header.
//
// Each request (operation and 32-bit value) yields the characters of one printf
// conversion, one byte per result transfer, with last and the character count on the
// final one. A request is taken by the front end and queued (two deep), so requests
// keep flowing while the back end works, until the queue is full. The back end handles
// one conversion at a time: it takes it from the queue, forms the digits through a
// reciprocal multiply that divides by ten (or a nibble shift for hex), then emits the
// characters, holding the output while result_stall is high. Unknown operations are
// taken and yield nothing.
`include "printf_integer_char_formatter_defines.svh"

module printf_integer_char_formatter #(
	parameter int VALUE_BITS = pic_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pic_pkg::in_item_t  request,
	input  logic               request_valid,
	output logic               request_stall,
	output pic_pkg::out_item_t result,
	output logic               result_valid,
	input  logic               result_stall
);

	pic_pkg::q_status_t qstat;
	pic_pkg::cmd_t      front_cmd;
	pic_pkg::cmd_t      back_cmd;
	logic               push;
	logic               pop;

	pic_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.request      (request),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.qstat        (qstat),
		.push         (push),
		.cmd          (front_cmd)
	);

	pic_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(front_cmd),
		.pop   (pop),
		.rd_cmd(back_cmd),
		.qstat (qstat)
	);

	pic_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (back_cmd),
		.qstat       (qstat),
		.pop         (pop),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	// Count appears only on the final character
	`PIC_ASSERT(a_total_only_on_last, result_valid && !result.last |-> result.total_chars == '0, "count on non-final character")
	// Final character carries a count in range
	`PIC_ASSERT(a_total_range, result_valid && result.last |-> result.total_chars != '0 && result.total_chars <= pic_pkg::CNT_W'(pic_pkg::DIGIT_DEPTH), "final count out of range")
	// Unknown operations never reach the queue
	`PIC_ASSERT(a_unknown_dropped, request_valid && !request_stall && request.operation > pic_pkg::OP_HEX_UPPER |-> !push, "unknown operation queued")
	// Reset clears the result channel
	`PIC_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !result_valid, "result valid during reset")

endmodule
